// ===== hdl/bps_pkg.sv =====
package bps_pkg;

  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned PIX_W      = 64;
  localparam int unsigned POS_W      = 22;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_DATA_W  = 2 * POS_W + 4 * PIX_W;
  localparam int unsigned IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 4 * CHAN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] SIZE_RESET = 13'd4096;

  // widen one lane to 16 bits; an 8-bit lane v becomes v * 257
  function automatic logic [CHAN_W-1:0] lane(input logic [PIX_W-1:0] pix,
                                             input logic [1:0] k,
                                             input logic wide);
    logic [7:0] narrow;
    narrow = pix[8*k +: 8];
    if (wide) begin
      return pix[16*k +: 16];
    end
    return {narrow, narrow};
  endfunction

endpackage

// ===== hdl/bilinear_premultiplied_sampler.sv =====
// Throughput: one item per clock; four arithmetic stages, then 16 restoring
// divider stages (one quotient bit each), then the output register.
// A stall on the master side fills bubbles first, then holds the whole pipe.
// Reset clears all valid bits and sets 8-bit lanes and a 4096 x 4096 image.
module bilinear_premultiplied_sampler #(
  parameter int unsigned POSITION_FRACTION_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bps_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // pos_x, pos_y, pixel_top_left, pixel_top_right, pixel_bottom_left,
  // pixel_bottom_right, zero padding
  input  logic [bps_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // red, green, blue, alpha
  output logic [bps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // sample_valid
  output logic [0:0]                         m_axis_tuser_o
);

  localparam int unsigned F    = POSITION_FRACTION_BITS;
  localparam int unsigned CH   = bps_pkg::CHAN_W;
  localparam int unsigned WW   = 2 * F + 1;
  localparam int unsigned AW   = CH + 2 * F;
  localparam int unsigned PW   = 2 * CH + 2 * F;
  localparam int unsigned PM   = bps_pkg::POS_W - 1;
  localparam int unsigned CW   = (PM > bps_pkg::CFG_W + F) ? PM : bps_pkg::CFG_W + F;
  localparam int unsigned NDIV = CH;
  localparam int unsigned NST  = 4 + NDIV + 1;

  localparam logic [F:0]    SF     = (F+1)'(1) << F;
  localparam logic [AW+1:0] HALF_Z = (AW+2)'(1) << (2 * F - 1);
  localparam logic [AW:0]   HALF_A = (AW+1)'(1) << (2 * F - 1);

  typedef struct packed {
    logic                       ok;
    logic [3:0][WW-1:0]         w;
    logic [3:0][CH-1:0]         a;
    logic [3:0][2:0][CH-1:0]    c;
  } st1_t;

  typedef struct packed {
    logic                       ok;
    logic [3:0][WW-1:0]         w;
    logic [3:0][AW-1:0]         aw;
    logic [3:0][2:0][2*CH-1:0]  ca;
    logic [3:0][2:0][AW-1:0]    cw;
  } st2_t;

  typedef struct packed {
    logic                       ok;
    logic [AW-1:0]              asum;
    logic [2:0][CH-1:0]         zc;
    logic [3:0][2:0][PW-1:0]    pw;
  } st3_t;

  typedef struct packed {
    logic                       ok;
    logic                       az;
    logic [AW-1:0]              asum;
    logic [CH-1:0]              alpha;
    logic [2:0][CH-1:0]         zc;
    logic [2:0][AW-1:0]         rem;
    logic [2:0][CH-1:0]         lo;
    logic [2:0][CH-1:0]         q;
  } div_t;

  typedef struct packed {
    logic                       ok;
    logic [3:0][CH-1:0]         rgba;
  } out_t;

  logic                       wide_q;
  logic [bps_pkg::CFG_W-1:0]  width_q;
  logic [bps_pkg::CFG_W-1:0]  height_q;

  logic [NST-1:0]             v_q;
  logic [NST-1:0]             en;

  st1_t  s1_q, s1_d;
  st2_t  s2_q, s2_d;
  st3_t  s3_q, s3_d;
  div_t  s4_d;
  div_t  div_q [NDIV+1];
  div_t  div_d [NDIV+1];
  out_t  out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q   <= 1'b0;
      width_q  <= bps_pkg::SIZE_RESET;
      height_q <= bps_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bps_pkg::CFG_WIDE:   wide_q   <= cfg_data_i[0];
        bps_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        bps_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance a stage when it or some later stage is empty, or the master side accepts
  for (genvar g = 0; g < NST; g++) begin : g_en
    assign en[g] = m_axis_tready_i || !(&v_q[NST-1:g]);
  end

  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // stage 1: bounds check, weights, lane extraction
  always_comb begin
    logic [CW-1:0]  mag_x, mag_y, lim_x, lim_y;
    logic           ok_x, ok_y;
    logic [F-1:0]   tx, ty;
    logic [F:0]     sx, sy;
    logic [2*F+1:0] p0, p1, p2, p3;
    logic [bps_pkg::PIX_W-1:0] pix;
    mag_x = CW'(s_axis_tdata_i[PM-1:0]);
    mag_y = CW'(s_axis_tdata_i[bps_pkg::POS_W +: PM]);
    lim_x = CW'(width_q - 13'd1) << F;
    lim_y = CW'(height_q - 13'd1) << F;
    ok_x  = (width_q != '0) && !s_axis_tdata_i[PM] && (mag_x <= lim_x);
    ok_y  = (height_q != '0) && !s_axis_tdata_i[bps_pkg::POS_W + PM] && (mag_y <= lim_y);
    tx    = s_axis_tdata_i[F-1:0];
    ty    = s_axis_tdata_i[bps_pkg::POS_W +: F];
    sx    = SF - {1'b0, tx};
    sy    = SF - {1'b0, ty};
    p0    = sx * sy;
    p1    = {1'b0, tx} * sy;
    p2    = sx * {1'b0, ty};
    p3    = {1'b0, tx} * {1'b0, ty};
    s1_d.ok   = ok_x && ok_y;
    s1_d.w[0] = p0[WW-1:0];
    s1_d.w[1] = p1[WW-1:0];
    s1_d.w[2] = p2[WW-1:0];
    s1_d.w[3] = p3[WW-1:0];
    for (int i = 0; i < 4; i++) begin
      pix = s_axis_tdata_i[2*bps_pkg::POS_W + i*bps_pkg::PIX_W +: bps_pkg::PIX_W];
      s1_d.a[i] = bps_pkg::lane(pix, 2'd3, wide_q);
      for (int j = 0; j < 3; j++) begin
        s1_d.c[i][j] = bps_pkg::lane(pix, 2'(j), wide_q);
      end
    end
  end

  // stage 2: alpha times weight, colour times alpha, colour times weight
  always_comb begin
    logic [AW:0] t_aw, t_cw;
    s2_d.ok = s1_q.ok;
    s2_d.w  = s1_q.w;
    for (int i = 0; i < 4; i++) begin
      t_aw = s1_q.a[i] * s1_q.w[i];
      s2_d.aw[i] = t_aw[AW-1:0];
      for (int j = 0; j < 3; j++) begin
        s2_d.ca[i][j] = s1_q.c[i][j] * s1_q.a[i];
        t_cw = s1_q.c[i][j] * s1_q.w[i];
        s2_d.cw[i][j] = t_cw[AW-1:0];
      end
    end
  end

  // stage 3: alpha sum, zero-alpha colour, premultiplied colour terms
  always_comb begin
    logic [AW+1:0] t_as, t_zs;
    logic [PW:0]   t_pw;
    t_as = {2'b0, s2_q.aw[0]} + {2'b0, s2_q.aw[1]}
         + {2'b0, s2_q.aw[2]} + {2'b0, s2_q.aw[3]};
    s3_d.ok   = s2_q.ok;
    s3_d.asum = t_as[AW-1:0];
    for (int j = 0; j < 3; j++) begin
      t_zs = {2'b0, s2_q.cw[0][j]} + {2'b0, s2_q.cw[1][j]}
           + {2'b0, s2_q.cw[2][j]} + {2'b0, s2_q.cw[3][j]} + HALF_Z;
      s3_d.zc[j] = t_zs[2*F +: CH];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        t_pw = s2_q.ca[i][j] * s2_q.w[i];
        s3_d.pw[i][j] = t_pw[PW-1:0];
      end
    end
  end

  // stage 4: rounded numerators, alpha output
  always_comb begin
    logic [PW+1:0] t_num;
    logic [AW:0]   t_al;
    t_al = {1'b0, s3_q.asum} + HALF_A;
    s4_d.ok    = s3_q.ok;
    s4_d.az    = (s3_q.asum == '0);
    s4_d.asum  = s3_q.asum;
    s4_d.alpha = t_al[2*F +: CH];
    s4_d.zc    = s3_q.zc;
    s4_d.q     = '0;
    for (int j = 0; j < 3; j++) begin
      t_num = {2'b0, s3_q.pw[0][j]} + {2'b0, s3_q.pw[1][j]}
            + {2'b0, s3_q.pw[2][j]} + {2'b0, s3_q.pw[3][j]}
            + (PW+2)'(s3_q.asum >> 1);
      s4_d.rem[j] = t_num[PW-1:CH];
      s4_d.lo[j]  = t_num[CH-1:0];
    end
  end

  // divider: one quotient bit per stage
  always_comb begin
    logic [AW:0] t;
    logic        ge;
    div_d[0] = s4_d;
    for (int k = 1; k <= NDIV; k++) begin
      div_d[k] = div_q[k-1];
      for (int j = 0; j < 3; j++) begin
        t  = {div_q[k-1].rem[j], div_q[k-1].lo[j][CH-1]};
        ge = (t >= {1'b0, div_q[k-1].asum});
        div_d[k].rem[j] = ge ? AW'(t - {1'b0, div_q[k-1].asum}) : t[AW-1:0];
        div_d[k].lo[j]  = {div_q[k-1].lo[j][CH-2:0], 1'b0};
        div_d[k].q[j]   = {div_q[k-1].q[j][CH-2:0], ge};
      end
    end
  end

  always_comb begin
    out_d.ok = div_q[NDIV].ok;
    for (int j = 0; j < 3; j++) begin
      if (!div_q[NDIV].ok) begin
        out_d.rgba[j] = '0;
      end else if (div_q[NDIV].az) begin
        out_d.rgba[j] = div_q[NDIV].zc[j];
      end else begin
        out_d.rgba[j] = div_q[NDIV].q[j];
      end
    end
    out_d.rgba[3] = div_q[NDIV].ok ? div_q[NDIV].alpha : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q <= s1_d;
    end
    if (en[1]) begin
      s2_q <= s2_d;
    end
    if (en[2]) begin
      s3_q <= s3_d;
    end
    for (int k = 0; k <= NDIV; k++) begin
      if (en[3+k]) begin
        div_q[k] <= div_d[k];
      end
    end
    if (en[NST-1]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o   = v_q[NST-1];
  assign m_axis_tdata_o    = out_q.rgba;
  assign m_axis_tuser_o[0] = out_q.ok;

endmodule

// ===== hdl/bps_checker.sv =====
module bps_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tready_o,
  input  logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic [bps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input  logic [0:0]                       m_axis_tuser_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result item changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("out-of-image item carries nonzero channels");

  a_ready_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i || !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input held off although the output has room");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result item offered right after reset");

endmodule

bind bilinear_premultiplied_sampler bps_checker u_bps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== bench/tb_top.sv =====
module tb_top;

  localparam int FRAC = 8;
  localparam longint unsigned SCALE = 64'd1 << FRAC;
  localparam longint unsigned ROUND_HALF = 64'd1 << (2 * FRAC - 1);
  localparam longint unsigned CH_MAX = 64'd65535;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 400;

  localparam logic [63:0] PIX_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PIX_M0 = 64'h1234_5678_C0FF_EE80;
  localparam logic [63:0] PIX_M1 = 64'h9ABC_DEF0_40A0_3010;
  localparam logic [63:0] PIX_M2 = 64'h0F1E_2D3C_FF00_7F01;
  localparam logic [63:0] PIX_M3 = 64'h8001_7FFE_2080_E0FE;

  typedef enum int {PIX_RANDOM, PIX_CLEAR, PIX_FAINT, PIX_OPAQUE} pix_style_e;

  typedef logic [bps_pkg::POS_W-1:0] pos_t;

  typedef struct {
    logic signed [bps_pkg::POS_W-1:0] pos_x;
    logic signed [bps_pkg::POS_W-1:0] pos_y;
    logic [bps_pkg::PIX_W-1:0]        top_left;
    logic [bps_pkg::PIX_W-1:0]        top_right;
    logic [bps_pkg::PIX_W-1:0]        bottom_left;
    logic [bps_pkg::PIX_W-1:0]        bottom_right;
  } sample_req_t;

  typedef struct packed {
    logic [bps_pkg::CHAN_W-1:0] red;
    logic [bps_pkg::CHAN_W-1:0] green;
    logic [bps_pkg::CHAN_W-1:0] blue;
    logic [bps_pkg::CHAN_W-1:0] alpha;
    logic                       valid;
  } pixel_out_t;

  typedef struct {
    logic                      wide;
    logic [bps_pkg::CFG_W-1:0] width;
    logic [bps_pkg::CFG_W-1:0] height;
    int                        px;
    int                        py;
    logic [bps_pkg::PIX_W-1:0] tl;
    logic [bps_pkg::PIX_W-1:0] tr;
    logic [bps_pkg::PIX_W-1:0] bl;
    logic [bps_pkg::PIX_W-1:0] br;
    bit                        typed;
    int                        red;
    int                        green;
    int                        blue;
    int                        alpha;
    int                        valid;
  } directed_row_t;

  typedef struct {
    logic                      wide;
    logic [bps_pkg::CFG_W-1:0] width;
    logic [bps_pkg::CFG_W-1:0] height;
    int                        count;
  } phase_t;

  logic                             clk_i;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [bps_pkg::CFG_IDX_W-1:0]    cfg_idx_i = bps_pkg::CFG_WIDE;
  logic [bps_pkg::CFG_W-1:0]        cfg_data_i = '0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [bps_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i = '0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [bps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic [0:0]                       m_axis_tuser_o;

  logic                      cfg_wide = 1'b0;
  logic [bps_pkg::CFG_W-1:0] cfg_width = bps_pkg::SIZE_RESET;
  logic [bps_pkg::CFG_W-1:0] cfg_height = bps_pkg::SIZE_RESET;

  pixel_out_t expected_pixels[$];
  directed_row_t directed_rows[$];
  phase_t phases[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  bilinear_premultiplied_sampler #(
    .POSITION_FRACTION_BITS (FRAC)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned channel16(logic [bps_pkg::PIX_W-1:0] pix, int k);
    longint unsigned v;
    if (cfg_wide) begin
      v = 64'(pix[16*k +: 16]);
      return (v > CH_MAX) ? CH_MAX : v;
    end
    v = 64'(pix[8*k +: 8]);
    return (v * CH_MAX + 127) / 255;
  endfunction

  function automatic pixel_out_t bilinear_sample(sample_req_t req);
    pixel_out_t res;
    longint sx, sy, lim_x, lim_y;
    longint unsigned tx, ty, sum_a, acc, v;
    longint unsigned w[4], a[4], col[3];
    logic [bps_pkg::PIX_W-1:0] pix[4];
    res = '0;
    sx = longint'(req.pos_x);
    sy = longint'(req.pos_y);
    if (cfg_width == 0 || cfg_height == 0) return res;
    lim_x = (longint'(cfg_width) - 1) * longint'(SCALE);
    lim_y = (longint'(cfg_height) - 1) * longint'(SCALE);
    if (sx < 0 || sy < 0 || sx > lim_x || sy > lim_y) return res;
    tx = longint'(sx) & (SCALE - 1);
    ty = longint'(sy) & (SCALE - 1);
    w[0] = (SCALE - tx) * (SCALE - ty);
    w[1] = tx * (SCALE - ty);
    w[2] = (SCALE - tx) * ty;
    w[3] = tx * ty;
    pix[0] = req.top_left;
    pix[1] = req.top_right;
    pix[2] = req.bottom_left;
    pix[3] = req.bottom_right;
    sum_a = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = channel16(pix[i], 3);
      sum_a += a[i] * w[i];
    end
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) begin
        if (sum_a != 0) acc += channel16(pix[i], c) * a[i] * w[i];
        else acc += channel16(pix[i], c) * w[i];
      end
      if (sum_a != 0) v = (acc + sum_a / 2) / sum_a;
      else v = (acc + ROUND_HALF) >> (2 * FRAC);
      col[c] = (v > CH_MAX) ? CH_MAX : v;
    end
    v = (sum_a + ROUND_HALF) >> (2 * FRAC);
    res.red = col[0][15:0];
    res.green = col[1][15:0];
    res.blue = col[2][15:0];
    res.alpha = (v > CH_MAX) ? 16'hFFFF : v[15:0];
    res.valid = 1'b1;
    return res;
  endfunction

  function automatic pos_t rand_coord(logic [bps_pkg::CFG_W-1:0] size);
    longint lim;
    int pick;
    lim = (size == 0) ? 0 : (longint'(size) - 1) * longint'(SCALE);
    pick = $urandom_range(99);
    if (pick < 15) return pos_t'($urandom);
    if (pick < 21) return pos_t'(lim);
    if (pick < 26) return pos_t'(lim + 1 + $urandom_range(255));
    if (pick < 30) return pos_t'(-1 - longint'($urandom_range(255)));
    if (pick < 33) return pos_t'($urandom_range(255));
    return pos_t'($urandom_range(0, int'(lim)));
  endfunction

  function automatic logic [bps_pkg::PIX_W-1:0] rand_pixel(pix_style_e style);
    logic [bps_pkg::PIX_W-1:0] p;
    logic [15:0] al;
    p = {$urandom, $urandom};
    case (style)
      PIX_CLEAR:  al = 16'h0000;
      PIX_FAINT:  al = 16'($urandom_range(1, 3));
      PIX_OPAQUE: al = 16'hFFFF;
      default:    al = p[63:48];
    endcase
    if (style != PIX_RANDOM) begin
      if (cfg_wide) p[63:48] = al;
      else p[31:24] = al[7:0];
    end
    return p;
  endfunction

  function automatic sample_req_t random_sample();
    sample_req_t req;
    bit all_clear;
    all_clear = ($urandom_range(9) == 0);
    req.pos_x = rand_coord(cfg_width);
    req.pos_y = rand_coord(cfg_height);
    req.top_left = rand_pixel(all_clear ? PIX_CLEAR : pix_style_e'($urandom_range(3)));
    req.top_right = rand_pixel(all_clear ? PIX_CLEAR : pix_style_e'($urandom_range(3)));
    req.bottom_left = rand_pixel(all_clear ? PIX_CLEAR : pix_style_e'($urandom_range(3)));
    req.bottom_right = rand_pixel(all_clear ? PIX_CLEAR : pix_style_e'($urandom_range(3)));
    return req;
  endfunction

  task automatic apply_config(input logic wide, input logic [bps_pkg::CFG_W-1:0] width,
                              input logic [bps_pkg::CFG_W-1:0] height);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= bps_pkg::CFG_WIDE;
    cfg_data_i <= {{(bps_pkg::CFG_W - 1){1'b0}}, wide};
    @(negedge clk_i);
    cfg_idx_i <= bps_pkg::CFG_WIDTH;
    cfg_data_i <= width;
    @(negedge clk_i);
    cfg_idx_i <= bps_pkg::CFG_HEIGHT;
    cfg_data_i <= height;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_wide = wide;
    cfg_width = width;
    cfg_height = height;
  endtask

  task automatic offer(input sample_req_t req, input bit typed, input pixel_out_t exp);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata_i <= {{(bps_pkg::IN_TDATA_W - bps_pkg::IN_DATA_W){1'b0}},
                       req.bottom_right, req.bottom_left,
                       req.top_right, req.top_left, req.pos_y, req.pos_x};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_pixels.insert(expected_pixels.size(), typed ? exp : bilinear_sample(req));
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    pixel_out_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.red = m_axis_tdata_o[15:0];
      got.green = m_axis_tdata_o[31:16];
      got.blue = m_axis_tdata_o[47:32];
      got.alpha = m_axis_tdata_o[63:48];
      got.valid = m_axis_tuser_o[0];
      if (expected_pixels.size() == 0) begin
        $error("item with no expected result: tdata %h tuser %b", m_axis_tdata_o,
               m_axis_tuser_o);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("alpha", want.alpha, got.alpha);
        check_field("sample_valid", want.valid, got.valid);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready_i <= calm || ($urandom_range(99) >= 7);
    end
  end

  initial begin
    sample_req_t req;
    pixel_out_t exp;
    directed_rows = '{
      '{0, 4096, 4096, -1, 0, PIX_ONES, PIX_ONES, PIX_ONES, PIX_ONES, 1, 0, 0, 0, 0, 0},
      '{0, 4096, 4096, 0, -2097152, PIX_ONES, PIX_M1, PIX_M2, PIX_M3,
        1, 0, 0, 0, 0, 0},
      '{0, 4096, 4096, 2097151, 0, PIX_M0, PIX_M1, PIX_M2, PIX_M3, 1, 0, 0, 0, 0, 0},
      '{0, 4096, 4096, 1048321, 0, PIX_ONES, PIX_ONES, PIX_ONES, PIX_ONES,
        1, 0, 0, 0, 0, 0},
      '{0, 4096, 4096, 0, 1048575, PIX_ONES, PIX_ONES, PIX_ONES, PIX_ONES,
        1, 0, 0, 0, 0, 0},
      '{0, 4096, 4096, 0, 0, PIX_ONES, PIX_M1, PIX_M2, PIX_M3,
        1, 65535, 65535, 65535, 65535, 1},
      '{0, 4096, 4096, 0, 0, 64'h0, 64'h0, 64'h0, 64'h0, 1, 0, 0, 0, 0, 1},
      '{0, 4096, 4096, 1048320, 1048320, 64'h0000_0000_FF00_0000, PIX_ONES, PIX_ONES,
        PIX_ONES, 1, 0, 0, 0, 65535, 1},
      '{0, 4096, 4096, 128, 128, PIX_M0, PIX_M1, PIX_M2, PIX_M3, 0, 0, 0, 0, 0, 0},
      '{0, 4096, 4096, 255, 255, PIX_M3, PIX_M2, PIX_M1, PIX_M0, 0, 0, 0, 0, 0, 0},
      '{0, 4096, 4096, 255, 255, 64'h0000_0001_01FF_8040, 64'h0000_0000_00FF_FFFF,
        64'h0000_0000_0012_3456, 64'h0000_0000_00FF_0000, 0, 0, 0, 0, 0, 0},
      '{0, 4096, 4096, 128, 64, 64'h0000_0000_00FF_8040, 64'h0000_0000_0010_20FF,
        64'hFFFF_FFFF_00FF_FFFF, 64'h0000_0000_0001_0203, 0, 0, 0, 0, 0, 0},
      '{0, 4096, 4096, 1048320, 200, PIX_M0, PIX_ONES, PIX_M2, PIX_ONES,
        0, 0, 0, 0, 0, 0},
      '{0, 4096, 4096, 300, 1048320, PIX_M1, PIX_M3, PIX_ONES, PIX_ONES,
        0, 0, 0, 0, 0, 0},
      '{1, 4096, 4096, 0, 0, PIX_ONES, PIX_M1, PIX_M2, PIX_M3,
        1, 65535, 65535, 65535, 65535, 1},
      '{1, 4096, 4096, 77, 201, PIX_M0, PIX_M1, PIX_M2, PIX_M3, 0, 0, 0, 0, 0, 0},
      '{1, 4096, 4096, 128, 128, 64'h0000_FFFF_8000_0001, 64'h0000_1234_5678_9ABC,
        64'h0000_0000_0000_0000, 64'h0000_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0},
      '{1, 4096, 4096, 1, 255, 64'h0001_FFFF_FFFF_FFFF, 64'h0000_FFFF_FFFF_FFFF,
        64'h0000_8000_8000_8000, 64'h0000_0001_0002_0003, 0, 0, 0, 0, 0, 0},
      '{1, 0, 4096, 0, 0, PIX_ONES, PIX_ONES, PIX_ONES, PIX_ONES, 1, 0, 0, 0, 0, 0},
      '{1, 4096, 0, 0, 0, PIX_ONES, PIX_ONES, PIX_ONES, PIX_ONES, 1, 0, 0, 0, 0, 0},
      '{0, 1, 1, 0, 0, PIX_M2, PIX_M1, PIX_M0, PIX_M3, 0, 0, 0, 0, 0, 0},
      '{0, 1, 1, 1, 0, PIX_ONES, PIX_ONES, PIX_ONES, PIX_ONES, 1, 0, 0, 0, 0, 0},
      '{0, 8191, 8191, 2096640, 2096640, PIX_M1, PIX_M2, PIX_M3, PIX_M0,
        0, 0, 0, 0, 0, 0},
      '{0, 8191, 8191, 2096641, 0, PIX_ONES, PIX_ONES, PIX_ONES, PIX_ONES,
        1, 0, 0, 0, 0, 0},
      '{1, 8191, 8191, 2097151, 2097151, PIX_ONES, PIX_ONES, PIX_ONES, PIX_ONES,
        1, 0, 0, 0, 0, 0}
    };
    phases = '{
      '{0, 4096, 4096, 300},
      '{1, 4096, 4096, 250},
      '{0, 1, 1, 100},
      '{1, 8191, 8191, 200},
      '{0, 37, 5, 250},
      '{1, 0, 12, 50},
      '{0, 2, 4096, 150},
      '{1, 300, 1, 250}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].wide != cfg_wide || directed_rows[r].width != cfg_width ||
          directed_rows[r].height != cfg_height)
        apply_config(directed_rows[r].wide, directed_rows[r].width, directed_rows[r].height);
      req.pos_x = pos_t'(directed_rows[r].px);
      req.pos_y = pos_t'(directed_rows[r].py);
      req.top_left = directed_rows[r].tl;
      req.top_right = directed_rows[r].tr;
      req.bottom_left = directed_rows[r].bl;
      req.bottom_right = directed_rows[r].br;
      exp.red = 16'(directed_rows[r].red);
      exp.green = 16'(directed_rows[r].green);
      exp.blue = 16'(directed_rows[r].blue);
      exp.alpha = 16'(directed_rows[r].alpha);
      exp.valid = 1'(directed_rows[r].valid);
      offer(req, directed_rows[r].typed, exp);
    end

    foreach (phases[p]) begin
      apply_config(phases[p].wide, phases[p].width, phases[p].height);
      calm = (p == 4);
      for (int n = 0; n < phases[p].count; n++) begin
        if (p == 0 && n == 120) hold_req = 1'b1;
        offer(random_sample(), 1'b0, '0);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
